FILE: rtl/streaming_field_tokenizer_macros.svh
// Assertion macros shared by the field tokenizer RTL.
`ifndef STREAMING_FIELD_TOKENIZER_MACROS_SVH
`define STREAMING_FIELD_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds whenever ante holds, outside reset.
`define SFT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante, outside reset.
`define SFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Check that cond never holds, outside reset.
`define SFT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define SFT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define SFT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/sft_pkg.sv
// Shared types and constants of the field tokenizer.
`timescale 1ns / 1ps
package sft_pkg;

  localparam int OFFSET_BITS_DEF   = 16;
  localparam int MAX_SEPARATOR_DEF = 8;

  localparam int TOKEN_W    = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SEP_LEN_W  = 4;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT_CODE = 8'h80;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_SEP_LEN   = 2'd1,
    CFG_SEP_BYTES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] tok_start;
    logic [TOKEN_W-1:0] tok_length;
    logic [TOKEN_W-1:0] tok_runes;
    logic               tok_last;
  } tok_result_t;

endpackage

FILE: rtl/streaming_field_tokenizer.sv
// Top level of the streaming field tokenizer: scanner, line state and result queue.
`timescale 1ns / 1ps
`include "streaming_field_tokenizer_macros.svh"

// Channel  Handshake            Payload                                               Dir
// -------  -------------------  ----------------------------------------------------  ---
// input    in_valid/in_stall    data_byte, byte_present, end_of_line                  in
// output   out_valid/out_stall  token_start, token_length, char_offset, last_of_line  out
// config   cfg_write_enable     cfg_index, cfg_data                                   in
//
// One input transaction per cycle sustained while in_stall is low; a byte lands in
// the input register, is scanned there once the queue has room for two results,
// and its results are registered in a four-entry result queue. An item makes 0..2
// results; the queue drains one transaction per cycle while out_stall is low, so
// the output rate caps the sustained input rate. in_stall rises while the input
// register holds an item and the queue has fewer than two free entries.
// rst is synchronous: it clears the line state, the registers to their defaults
// and empties the queue.
module streaming_field_tokenizer
  import sft_pkg::*;
#(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int MAX_SEPARATOR = MAX_SEPARATOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input bytes
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  byte_present,
  input  logic                  end_of_line,
  // field results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TOKEN_W-1:0]    token_start,
  output logic [TOKEN_W-1:0]    token_length,
  output logic [TOKEN_W-1:0]    char_offset,
  output logic                  last_of_line
);

  localparam int OB     = OFFSET_BITS;
  localparam int SEP_W  = 8 * MAX_SEPARATOR;
  localparam int FILL_W = $clog2(MAX_SEPARATOR + 1);
  localparam logic [OB-1:0]        OFF_MAX  = '1;
  localparam logic [SEP_LEN_W-1:0] SEP_CAP  = SEP_LEN_W'(MAX_SEPARATOR);
  localparam logic [FILL_W-1:0]    FILL_CAP = FILL_W'(MAX_SEPARATOR);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIELD = 2'd1,
    PH_BLANK = 2'd2
  } phase_t;

  // Configuration registers.
  logic                 mode;
  logic [SEP_LEN_W-1:0] sep_len;
  logic [SEP_W-1:0]     sep_bytes;

  // Input register.
  logic       in_reg_valid;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_eol;

  // Line state.
  phase_t            phase;
  logic [OB-1:0]     field_begin;
  logic [OB-1:0]     field_end;
  logic [OB-1:0]     byte_position;
  logic [OB-1:0]     character_count;
  logic [OB-1:0]     begin_character_count;
  logic [SEP_W-1:0]  recent_bytes;
  logic [FILL_W-1:0] recent_fill;

  phase_t            phase_next;
  logic [OB-1:0]     field_begin_next;
  logic [OB-1:0]     field_end_next;
  logic [OB-1:0]     byte_position_next;
  logic [OB-1:0]     character_count_next;
  logic [OB-1:0]     begin_character_count_next;
  logic [SEP_W-1:0]  recent_bytes_next;
  logic [FILL_W-1:0] recent_fill_next;

  // Result queue.
  tok_result_t          res_queue [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] res_count;

  logic          proc_fire;
  logic          in_fire;
  logic          out_fire;
  logic          byte_res_valid;
  tok_result_t   byte_res;
  logic          eol_res_valid;
  tok_result_t   eol_res;
  logic [1:0]    push_n;
  tok_result_t   push_first;
  logic [SEP_LEN_W-1:0] eff_len;
  logic          sep_match;

  function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tok_result_t make_result(input logic [OB-1:0] b,
                                              input logic [OB-1:0] e,
                                              input logic [OB-1:0] runes,
                                              input logic          last);
    tok_result_t r;
    r.tok_start  = TOKEN_W'(b);
    r.tok_length = (e >= b) ? TOKEN_W'(e - b) : '0;
    r.tok_runes  = TOKEN_W'(runes);
    r.tok_last   = last;
    return r;
  endfunction

  // Scan the queued item once there is room for two results.
  assign proc_fire = in_reg_valid && (res_count <= RES_CNT_W'(RES_DEPTH - 2));
  assign in_stall  = in_reg_valid && !proc_fire;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (res_count != '0);
  assign out_fire  = out_valid && !out_stall;

  assign token_start  = res_queue[rd_ptr].tok_start;
  assign token_length = res_queue[rd_ptr].tok_length;
  assign char_offset  = res_queue[rd_ptr].tok_runes;
  assign last_of_line = res_queue[rd_ptr].tok_last;

  assign eff_len = (sep_len > SEP_CAP) ? SEP_CAP : sep_len;

  // Separator compare: the newest byte pairs with the last separator byte.
  always_comb begin
    logic [SEP_W-1:0] shifted;
    shifted   = SEP_W'({recent_bytes, in_byte});
    sep_match = 1'b1;
    for (int k = 0; k < MAX_SEPARATOR; k++) begin
      for (int j = 0; j < MAX_SEPARATOR; j++) begin
        if ((SEP_LEN_W'(k) < eff_len) && (SEP_LEN_W'(k + j + 1) == eff_len) &&
            (shifted[8*k +: 8] != sep_bytes[8*j +: 8])) begin
          sep_match = 1'b0;
        end
      end
    end
  end

  // Per-item scan: byte first, then the end of line.
  always_comb begin
    logic [OB-1:0] nxt;
    logic [OB-1:0] cc_after;
    logic          cont;
    logic          white;
    logic [FILL_W-1:0] fill_inc;

    nxt      = sat_inc(byte_position);
    cont     = (in_byte & UTF8_CONT_MASK) == UTF8_CONT_CODE;
    cc_after = cont ? character_count : sat_inc(character_count);
    white    = (in_byte == CHAR_TAB) || (in_byte == CHAR_SPACE) ||
               (in_byte == CHAR_NEWLINE);
    fill_inc = (recent_fill == FILL_CAP) ? recent_fill : recent_fill + 1'b1;

    phase_next                 = phase;
    field_begin_next           = field_begin;
    field_end_next             = field_end;
    byte_position_next         = byte_position;
    character_count_next       = character_count;
    begin_character_count_next = begin_character_count;
    recent_bytes_next          = recent_bytes;
    recent_fill_next           = recent_fill;
    byte_res_valid             = 1'b0;
    byte_res                   = make_result(field_begin, field_end,
                                             begin_character_count, 1'b0);
    eol_res_valid              = 1'b0;

    if (in_present) begin
      if (!mode) begin
        unique case (phase)
          PH_IDLE: begin
            if (!white) begin
              phase_next                 = PH_FIELD;
              field_begin_next           = byte_position;
              begin_character_count_next = character_count;
              field_end_next             = nxt;
            end
          end
          PH_FIELD: begin
            field_end_next = nxt;
            if (white) begin
              phase_next = PH_BLANK;
            end
          end
          default: begin
            if (white) begin
              field_end_next = nxt;
            end else begin
              byte_res_valid             = 1'b1;
              phase_next                 = PH_FIELD;
              field_begin_next           = byte_position;
              begin_character_count_next = character_count;
              field_end_next             = nxt;
            end
          end
        endcase
      end else if (eff_len == '0) begin
        // One field per UTF-8 character.
        if (phase != PH_FIELD) begin
          phase_next                 = PH_FIELD;
          field_begin_next           = byte_position;
          begin_character_count_next = character_count;
        end else if (!cont) begin
          byte_res_valid             = 1'b1;
          byte_res                   = make_result(field_begin, byte_position,
                                                   begin_character_count, 1'b0);
          field_begin_next           = byte_position;
          begin_character_count_next = character_count;
        end
      end else begin
        recent_bytes_next = SEP_W'({recent_bytes, in_byte});
        recent_fill_next  = fill_inc;
        if ((SEP_LEN_W'(fill_inc) >= eff_len) && sep_match) begin
          byte_res_valid             = 1'b1;
          byte_res                   = make_result(field_begin, nxt,
                                                   begin_character_count, 1'b0);
          field_begin_next           = nxt;
          begin_character_count_next = cc_after;
          recent_fill_next           = '0;
        end
      end
      character_count_next = cc_after;
      byte_position_next   = nxt;
    end

    if (!mode) begin
      eol_res_valid = in_eol && (phase_next != PH_IDLE);
      eol_res       = make_result(field_begin_next, field_end_next,
                                  begin_character_count_next, 1'b1);
    end else begin
      eol_res_valid = in_eol && ((eff_len != '0) || (phase_next == PH_FIELD));
      eol_res       = make_result(field_begin_next, byte_position_next,
                                  begin_character_count_next, 1'b1);
    end

    // Drop all line state at the end of the line.
    if (in_eol) begin
      phase_next                 = PH_IDLE;
      field_begin_next           = '0;
      field_end_next             = '0;
      byte_position_next         = '0;
      character_count_next       = '0;
      begin_character_count_next = '0;
      recent_bytes_next          = '0;
      recent_fill_next           = '0;
    end
  end

  assign push_n     = proc_fire ? (2'(byte_res_valid) + 2'(eol_res_valid)) : 2'd0;
  assign push_first = byte_res_valid ? byte_res : eol_res;

  // Control and line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= 1'b0;
      sep_len               <= SEP_LEN_W'(1);
      sep_bytes             <= '0;
      in_reg_valid          <= 1'b0;
      phase                 <= PH_IDLE;
      field_begin           <= '0;
      field_end             <= '0;
      byte_position         <= '0;
      character_count       <= '0;
      begin_character_count <= '0;
      recent_bytes          <= '0;
      recent_fill           <= '0;
      wr_ptr                <= '0;
      rd_ptr                <= '0;
      res_count             <= '0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          CFG_MODE:      mode      <= cfg_data[0];
          CFG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
          CFG_SEP_BYTES: sep_bytes <= cfg_data[SEP_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        in_reg_valid <= 1'b1;
      end else if (proc_fire) begin
        in_reg_valid <= 1'b0;
      end
      if (proc_fire) begin
        phase                 <= phase_next;
        field_begin           <= field_begin_next;
        field_end             <= field_end_next;
        byte_position         <= byte_position_next;
        character_count       <= character_count_next;
        begin_character_count <= begin_character_count_next;
        recent_bytes          <= recent_bytes_next;
        recent_fill           <= recent_fill_next;
      end
      wr_ptr    <= wr_ptr + RES_PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      res_count <= res_count + RES_CNT_W'(push_n) - RES_CNT_W'(out_fire);
    end
  end

  // Payload registers: input item and queue entries.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte    <= data_byte;
      in_present <= byte_present;
      in_eol     <= end_of_line;
    end
    if (push_n != 2'd0) begin
      res_queue[wr_ptr] <= push_first;
    end
    if (push_n == 2'd2) begin
      res_queue[wr_ptr + 1'b1] <= eol_res;
    end
  end

  `SFT_ASSERT_NEVER(a_queue_bound, clk, rst, res_count > RES_CNT_W'(RES_DEPTH),
    "result queue count beyond depth")
  `SFT_ASSERT_NEXT(a_line_clear, clk, rst, proc_fire && in_eol,
    byte_position == '0 && phase == PH_IDLE && recent_fill == '0,
    "line state not cleared after end of line")
  `SFT_ASSERT_NEVER(a_begin_order, clk, rst,
    field_begin > byte_position || begin_character_count > character_count,
    "field start runs ahead of the line position")
  `SFT_ASSERT_IMP(a_fill_cap, clk, rst, 1'b1, recent_fill <= FILL_CAP,
    "separator fill count beyond separator bound")

endmodule

FILE: test/field_checker.sv
// Field checker: predicts tokenizer results from accepted bytes and compares them.
`timescale 1ns / 1ps

module field_checker
  import sft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  byte_present,
  input  logic                  end_of_line,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [TOKEN_W-1:0]    token_start,
  input  logic [TOKEN_W-1:0]    token_length,
  input  logic [TOKEN_W-1:0]    char_offset,
  input  logic                  last_of_line,
  output int                    mismatch_count,
  output int                    fields_pending
);

  typedef enum logic [1:0] {
    SCAN_IDLE  = 2'd0,
    SCAN_FIELD = 2'd1,
    SCAN_BLANK = 2'd2
  } scan_phase_t;

  // register copies
  logic                  mode_q;
  logic [SEP_LEN_W-1:0]  sep_len_q;
  logic [63:0]           sep_q;

  // line state
  scan_phase_t           phase;
  logic [TOKEN_W-1:0]    field_lo;
  logic [TOKEN_W-1:0]    field_hi;
  logic [TOKEN_W-1:0]    line_pos;
  logic [TOKEN_W-1:0]    char_total;
  logic [TOKEN_W-1:0]    field_chars;
  logic [63:0]           history;
  logic [3:0]            history_fill;

  tok_result_t           expected_fields[$];

  initial mismatch_count = 0;
  initial fields_pending = 0;

  function automatic logic [TOKEN_W-1:0] bump(input logic [TOKEN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_line();
    phase        = SCAN_IDLE;
    field_lo     = '0;
    field_hi     = '0;
    line_pos     = '0;
    char_total   = '0;
    field_chars  = '0;
    history      = '0;
    history_fill = '0;
  endfunction

  function automatic void emit_field(input logic [TOKEN_W-1:0] lo, input logic [TOKEN_W-1:0] hi,
                                     input logic [TOKEN_W-1:0] chars, input logic last);
    tok_result_t t;
    t.tok_start  = lo;
    t.tok_length = (hi >= lo) ? hi - lo : '0;
    t.tok_runes  = chars;
    t.tok_last   = last;
    expected_fields.insert(expected_fields.size(), t);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("[%0t] field mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Advance the line state by one transaction and queue the fields it closes.
  task automatic scan_item(input logic [7:0] b, input logic present, input logic eol);
    int unsigned         n;
    logic [TOKEN_W-1:0]  here;
    logic [TOKEN_W-1:0]  next;
    logic [TOKEN_W-1:0]  chars_after;
    logic                cont;
    logic                blank;
    logic                match;
    n = (sep_len_q > MAX_SEPARATOR_DEF) ? MAX_SEPARATOR_DEF : sep_len_q;
    if (present) begin
      here        = line_pos;
      next        = bump(line_pos);
      cont        = (b & UTF8_CONT_MASK) == UTF8_CONT_CODE;
      chars_after = cont ? char_total : bump(char_total);
      if (!mode_q) begin
        blank = (b == CHAR_TAB) || (b == CHAR_SPACE) || (b == CHAR_NEWLINE);
        case (phase)
          SCAN_IDLE: begin
            if (!blank) begin
              phase       = SCAN_FIELD;
              field_lo    = here;
              field_chars = char_total;
              field_hi    = next;
            end
          end
          SCAN_FIELD: begin
            field_hi = next;
            if (blank) phase = SCAN_BLANK;
          end
          default: begin
            if (blank) begin
              field_hi = next;
            end else begin
              emit_field(field_lo, field_hi, field_chars, 1'b0);
              phase       = SCAN_FIELD;
              field_lo    = here;
              field_chars = char_total;
              field_hi    = next;
            end
          end
        endcase
      end else if (n == 0) begin
        if (phase != SCAN_FIELD) begin
          phase       = SCAN_FIELD;
          field_lo    = here;
          field_chars = char_total;
        end else if (!cont) begin
          emit_field(field_lo, here, field_chars, 1'b0);
          field_lo    = here;
          field_chars = char_total;
        end
      end else begin
        history = {history[55:0], b};
        if (history_fill < 8) history_fill++;
        match = (history_fill >= n);
        // newest byte sits low in history, the separator's first byte low in sep_q
        for (int k = 0; k < n; k++)
          if (history[8*k +: 8] != sep_q[8*(n-1-k) +: 8]) match = 1'b0;
        if (match) begin
          emit_field(field_lo, next, field_chars, 1'b0);
          field_lo     = next;
          field_chars  = chars_after;
          history_fill = '0;
        end
      end
      char_total = chars_after;
      line_pos   = next;
    end
    if (eol) begin
      if (!mode_q) begin
        if (phase != SCAN_IDLE) emit_field(field_lo, field_hi, field_chars, 1'b1);
      end else if (n == 0) begin
        if (phase == SCAN_FIELD) emit_field(field_lo, line_pos, field_chars, 1'b1);
      end else begin
        emit_field(field_lo, line_pos, field_chars, 1'b1);
      end
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    tok_result_t want;
    if (rst) begin
      mode_q    = 1'b0;
      sep_len_q = SEP_LEN_W'(1);
      sep_q     = '0;
      clear_line();
      expected_fields.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report_mismatch($sformatf("unexpected field start %0d length %0d",
                                    token_start, token_length));
        end else begin
          want = expected_fields.pop_front();
          if (token_start != want.tok_start)
            report_mismatch($sformatf("token_start %0d, want %0d", token_start, want.tok_start));
          if (token_length != want.tok_length)
            report_mismatch($sformatf("token_length %0d, want %0d",
                                      token_length, want.tok_length));
          if (char_offset != want.tok_runes)
            report_mismatch($sformatf("char_offset %0d, want %0d", char_offset, want.tok_runes));
          if (last_of_line != want.tok_last)
            report_mismatch($sformatf("last_of_line %0b, want %0b", last_of_line, want.tok_last));
        end
      end
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_MODE:      mode_q    = cfg_data[0];
          CFG_SEP_LEN:   sep_len_q = cfg_data[SEP_LEN_W-1:0];
          CFG_SEP_BYTES: sep_q     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_item(data_byte, byte_present, end_of_line);
    end
    fields_pending <= expected_fields.size();
  end

endmodule

FILE: test/tb.sv
// Testbench top: drives lines of bytes into the field tokenizer and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import sft_pkg::*;

  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 160;
  localparam int LONG_LINE_BYTES = 200;    // well past the random line lengths
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;      // input register plus scan stage, with margin

  logic                  clk;
  logic                  rst              = 1'b1;
  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte        = '0;
  logic                  byte_present     = 1'b0;
  logic                  end_of_line      = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [TOKEN_W-1:0]    token_start;
  logic [TOKEN_W-1:0]    token_length;
  logic [TOKEN_W-1:0]    char_offset;
  logic                  last_of_line;

  int mismatch_count;
  int fields_pending;
  int idle_cycles = 0;
  int items_sent  = 0;

  // idling odds in percent per cycle, set per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // settings last written, used to shape the byte stream
  logic        gen_mode = 1'b0;
  logic [3:0]  gen_len  = 4'd1;
  logic [63:0] gen_sep  = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  streaming_field_tokenizer u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .byte_present     (byte_present),
    .end_of_line      (end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .token_start      (token_start),
    .token_length     (token_length),
    .char_offset      (char_offset),
    .last_of_line     (last_of_line)
  );

  field_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .byte_present     (byte_present),
    .end_of_line      (end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .token_start      (token_start),
    .token_length     (token_length),
    .char_offset      (char_offset),
    .last_of_line     (last_of_line),
    .mismatch_count   (mismatch_count),
    .fields_pending   (fields_pending)
  );

  // Receiver back-pressure: redraw the stall on every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a long run of cycles with no transaction on any port means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("streaming_field_tokenizer test failed");
        $finish;
      end
    end
  end

  // Send one input transaction. Entered and left just after a falling edge, with
  // in_valid still high on return so back-to-back items keep it up.
  task automatic send_item(input logic [7:0] b, input logic present, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    byte_present <= present;
    end_of_line  <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (present || eol) items_sent++;
  endtask

  // Drop valid and hold off until every predicted field has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (fields_pending != 0);
    @(negedge clk);
  endtask

  // Register writes need an idle block: drain, then cover an item still in flight
  // that produces nothing.
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles; junk in the unused upper bits.
  task automatic program_regs(input logic mode, input logic [3:0] len, input logic [63:0] sep);
    logic [63:0] filler;
    filler = {$urandom, $urandom};
    cfg_write_enable <= 1'b1;
    cfg_index        <= CFG_MODE;
    cfg_data         <= {filler[63:1], mode};
    @(negedge clk);
    cfg_index        <= CFG_SEP_LEN;
    cfg_data         <= {filler[63:4], len};
    @(negedge clk);
    cfg_index        <= CFG_SEP_BYTES;
    cfg_data         <= sep;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    gen_mode = mode;
    gen_len  = len;
    gen_sep  = sep;
  endtask

  // Build a line from chunks (separators, blanks, words, UTF-8 characters, noise)
  // and send it, closing it when asked.
  task automatic send_line(input bit close);
    logic [7:0]  bytes[$];
    int unsigned want;
    int unsigned r;
    int unsigned n;
    int unsigned cut;
    bit          bare_close;
    r    = $urandom_range(99);
    want = (r < 8) ? 0 : (r < 80) ? $urandom_range(1, 24) : $urandom_range(25, 80);
    n    = (gen_len > MAX_SEPARATOR_DEF) ? MAX_SEPARATOR_DEF : gen_len;
    while (bytes.size() < want) begin
      r = $urandom_range(99);
      if (r < 25 && n > 0) begin
        // mostly whole separators; now and then a prefix broken by a stray byte
        cut = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
        for (int k = 0; k < cut; k++) bytes.insert(bytes.size(), gen_sep[8*k +: 8]);
        if (cut < n) bytes.insert(bytes.size(), 8'($urandom_range(255)));
      end else if (r < 45) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(2))
            0:       bytes.insert(bytes.size(), CHAR_TAB);
            1:       bytes.insert(bytes.size(), CHAR_SPACE);
            default: bytes.insert(bytes.size(), CHAR_NEWLINE);
          endcase
        end
      end else if (r < 70) begin
        repeat ($urandom_range(1, 6)) bytes.insert(bytes.size(), 8'($urandom_range(33, 126)));
      end else if (r < 88) begin
        cut = $urandom_range(1, 3);
        case (cut)
          1:       bytes.insert(bytes.size(), 8'hC0 | 8'($urandom_range(31)));
          2:       bytes.insert(bytes.size(), 8'hE0 | 8'($urandom_range(15)));
          default: bytes.insert(bytes.size(), 8'hF0 | 8'($urandom_range(7)));
        endcase
        repeat (cut) bytes.insert(bytes.size(), UTF8_CONT_CODE | 8'($urandom_range(63)));
      end else begin
        bytes.insert(bytes.size(), 8'($urandom_range(255)));
      end
    end
    // an empty line, or now and then a line closed by a byte-less transaction
    bare_close = close && (bytes.size() == 0 || $urandom_range(9) == 0);
    foreach (bytes[i]) begin
      if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(bytes[i], 1'b1, close && !bare_close && (i == bytes.size() - 1));
    end
    if (bare_close) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int          phase_start;
    bit          paused;
    int unsigned k;
    logic [3:0]  len;
    logic [63:0] sep;
    logic [7:0]  b;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Whitespace mode out of reset: leading blanks skipped, trailing blanks kept,
    // tab and newline as separators.
    send_item(CHAR_SPACE, 1'b1, 1'b0);
    send_item(CHAR_SPACE, 1'b1, 1'b0);
    send_item(8'h61,      1'b1, 1'b0);
    send_item(CHAR_TAB,   1'b1, 1'b0);
    send_item(8'h62,      1'b1, 1'b0);
    send_item(CHAR_SPACE, 1'b1, 1'b0);
    send_item(CHAR_NEWLINE, 1'b1, 1'b1);
    // empty line, idle item, then a line of blanks only: none of them report
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(CHAR_SPACE, 1'b1, 1'b0);
    send_item(CHAR_TAB,   1'b1, 1'b1);

    // Two-byte separator ",;": separator kept in the field, trailing empty field
    // reported, multi-byte character counted once.
    quiesce();
    program_regs(1'b1, 4'd2, 64'h3B2C);
    send_item(8'h78, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'h3B, 1'b1, 1'b0);
    send_item(8'hC3, 1'b1, 1'b0);
    send_item(8'hA9, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'h3B, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);   // empty line still gives one empty field

    // Character mode: stray continuation opens a character, 0xFF and 0x00 each
    // stand alone.
    quiesce();
    program_regs(1'b1, 4'd0, {$urandom, $urandom});
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b0);
    send_item(8'hAC, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    // One long whitespace-mode line, unthrottled, with sparse blanks and stray
    // continuation bytes.
    quiesce();
    program_regs(1'b0, 4'd1, '0);
    for (int i = 0; i < LONG_LINE_BYTES; i++) begin
      k = $urandom_range(199);
      b = (k == 0) ? CHAR_SPACE :
          (k < 4)  ? (UTF8_CONT_CODE | 8'($urandom_range(63))) : 8'($urandom_range(33, 126));
      send_item(b, 1'b1, i == LONG_LINE_BYTES - 1);
    end

    // Random phases. The first four pin the register extremes; a line may stay
    // open across a phase boundary so settings change mid-line.
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      k = $urandom_range(9);
      len = (k < 2) ? 4'd0 : (k < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(9, 15));
      case ($urandom_range(3))
        0:       sep = '0;
        1:       sep = '1;
        2:       sep = {8{8'($urandom_range(33, 126))}};   // self-overlapping separator
        default: for (int j = 0; j < 8; j++) sep[8*j +: 8] = 8'($urandom_range(33, 126));
      endcase
      case (ph)
        0:       program_regs(1'b1, 4'd8, '1);
        1:       program_regs(1'b1, 4'd0, sep);
        2:       program_regs(1'b0, 4'd15, '0);
        3:       program_regs(1'b1, 4'd15, sep);   // longer than the separator store
        default: program_regs($urandom_range(2) != 0, len, sep);
      endcase
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_line(1'b1);
        // pause the sender once per phase until the result queue runs dry
        if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      if ($urandom_range(1)) send_line(1'b0);
    end

    // Drain, give any stray result time to show, then report.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("streaming_field_tokenizer test passed");
    else
      $display("streaming_field_tokenizer test failed");
    $finish;
  end

endmodule
